// File: hw/rtl/vmm_pkg.sv
package vmm_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int LANES     = 4;
    localparam int PAIR_W    = SAMPLE_W + 1;
    localparam int SUM_W     = SAMPLE_W + 3;
    localparam int VOLTS_W   = 6;
    localparam int PERIOD_W  = 7;
    localparam int SEG_W     = 7;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 4;

    localparam logic [1:0] OP_BURST = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_BYTE  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_L      = 8'h4C;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_M = 8'h6D;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_M = 8'h4D;
    localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;

    localparam logic [VOLTS_W-1:0]  VOLTS_MIN_RESET = 6'd33;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 7'd100;

    // Item handed from the merge stage to the sequencer.
    typedef struct packed {
        logic [1:0]         op;
        logic [CHAR_W-1:0]  rx_byte;
        logic [VOLTS_W-1:0] volts;
    } t_item;

    // Tens digit of a value below 64: multiply by 205/2048.
    function automatic logic [DIGIT_W-1:0] tens_of(input logic [VOLTS_W-1:0] v);
        logic [13:0] prod;
        prod = {8'd0, v} * 14'd205;
        return {1'b0, prod[13:11]};
    endfunction

    function automatic logic [DIGIT_W-1:0] units_of(input logic [VOLTS_W-1:0] v);
        logic [DIGIT_W-1:0] q;
        logic [VOLTS_W-1:0] tenfold;
        q       = tens_of(v);
        // 8q + 2q = 10q
        tenfold = {q[2:0], 3'b000} + {2'b00, q[2:0], 1'b0};
        return 4'(v - tenfold);
    endfunction

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        return CHAR_ZERO + {4'd0, d};
    endfunction

endpackage

// File: hw/rtl/vmm_lane.sv
module vmm_lane (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [vmm_pkg::SAMPLE_W-1:0] i_sample_a,
    input  logic [vmm_pkg::SAMPLE_W-1:0] i_sample_b,
    output logic [vmm_pkg::PAIR_W-1:0]   o_sum
);

    logic [vmm_pkg::PAIR_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= {1'b0, i_sample_a} + {1'b0, i_sample_b};
        end
    end

    assign o_sum = r_sum;

endmodule

// File: hw/rtl/vmm_merge.sv
module vmm_merge (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [vmm_pkg::PAIR_W-1:0]  i_pair_sum [vmm_pkg::LANES],
    output logic [vmm_pkg::VOLTS_W-1:0] o_volts
);

    logic [vmm_pkg::SUM_W-1:0]    sum;
    logic [vmm_pkg::SAMPLE_W-1:0] avg;
    logic [15:0]                  scaled;
    logic [15:0]                  biased;
    logic [vmm_pkg::VOLTS_W-1:0]  r_volts;

    always_comb begin
        sum = '0;
        for (int i = 0; i < vmm_pkg::LANES; i++) begin
            sum = sum + {2'b00, i_pair_sum[i]};
        end
        avg    = sum[vmm_pkg::SUM_W-1:3];
        scaled = {1'b0, avg, 5'd0} + {6'd0, avg} + 16'd511;
        // Division by 1023 is exact for this range as (x + x/1024 + 1) / 1024.
        biased = scaled + {10'd0, scaled[15:10]} + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_volts <= biased[15:10];
        end
    end

    assign o_volts = r_volts;

endmodule

// File: hw/rtl/vmm_seq.sv
module vmm_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [vmm_pkg::PERIOD_W-1:0] i_cfg_wr_data,
    input  logic                         i_item_valid,
    input  vmm_pkg::t_item               i_item,
    output logic                         o_item_take,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_kind,
    output logic [vmm_pkg::SEG_W-1:0]    o_segments,
    output logic                         o_high_digit,
    output logic [vmm_pkg::CHAR_W-1:0]   o_tx_char,
    output logic                         o_last
);

    typedef enum logic {
        JOB_TICK,
        JOB_LIST
    } t_job;

    logic [vmm_pkg::PERIOD_W-1:0] r_period, n_period;
    logic [vmm_pkg::VOLTS_W-1:0]  r_now, n_now, r_min, n_min, r_max, n_max;
    logic                         r_toggle, n_toggle;
    logic [vmm_pkg::PERIOD_W-1:0] r_tick, n_tick;
    logic                         r_busy, n_busy;
    logic [3:0]                   r_idx, n_idx, r_last_idx, n_last_idx;
    t_job                         r_job, n_job;
    logic [vmm_pkg::SEG_W-1:0]    r_seg, n_seg;
    logic                         r_hi, n_hi;
    logic [vmm_pkg::DIGIT_W-1:0]  r_a1, n_a1, r_a0, n_a0, r_b1, n_b1, r_b0, n_b0;

    logic                         out_xfer;
    logic                         out_done;
    logic                         needs_slot;
    logic                         take;
    logic [vmm_pkg::DIGIT_W-1:0]  digit;
    logic [vmm_pkg::PERIOD_W:0]   next_count;
    logic                         report;

    always_comb begin
        n_period   = r_period;
        n_now      = r_now;
        n_min      = r_min;
        n_max      = r_max;
        n_toggle   = r_toggle;
        n_tick     = r_tick;
        n_busy     = r_busy;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        n_job      = r_job;
        n_seg      = r_seg;
        n_hi       = r_hi;
        n_a1       = r_a1;
        n_a0       = r_a0;
        n_b1       = r_b1;
        n_b0       = r_b0;

        out_xfer = r_busy && !i_stall;
        out_done = out_xfer && (r_idx == r_last_idx);
        if (out_xfer) begin
            n_idx = r_idx + 4'd1;
        end
        if (out_done) begin
            n_busy = 1'b0;
        end

        needs_slot = (i_item.op == vmm_pkg::OP_TICK) ||
                     ((i_item.op == vmm_pkg::OP_BYTE) && (i_item.rx_byte == vmm_pkg::CHAR_L));
        take       = i_item_valid && (!needs_slot || !r_busy || out_done);

        digit      = r_toggle ? vmm_pkg::tens_of(r_now) : vmm_pkg::units_of(r_now);
        next_count = {1'b0, r_tick} + 8'd1;
        report     = next_count >= {1'b0, r_period};

        if (take) begin
            case (i_item.op)
                vmm_pkg::OP_BURST: begin
                    n_now = i_item.volts;
                    if (i_item.volts < r_min) begin
                        n_min = i_item.volts;
                    end
                    if (i_item.volts > r_max) begin
                        n_max = i_item.volts;
                    end
                end
                vmm_pkg::OP_TICK: begin
                    n_seg      = vmm_pkg::seg_of(digit);
                    n_hi       = r_toggle;
                    n_toggle   = !r_toggle;
                    n_tick     = report ? '0 : next_count[vmm_pkg::PERIOD_W-1:0];
                    n_a1       = vmm_pkg::tens_of(r_now);
                    n_a0       = vmm_pkg::units_of(r_now);
                    n_job      = JOB_TICK;
                    n_idx      = 4'd0;
                    n_last_idx = report ? 4'd4 : 4'd0;
                    n_busy     = 1'b1;
                end
                vmm_pkg::OP_BYTE: begin
                    if (i_item.rx_byte == vmm_pkg::CHAR_L) begin
                        n_a1       = vmm_pkg::tens_of(r_min);
                        n_a0       = vmm_pkg::units_of(r_min);
                        n_b1       = vmm_pkg::tens_of(r_max);
                        n_b0       = vmm_pkg::units_of(r_max);
                        n_job      = JOB_LIST;
                        n_idx      = 4'd0;
                        n_last_idx = 4'd10;
                        n_busy     = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cfg_wr_en) begin
            n_period = i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= vmm_pkg::PERIOD_RESET;
            r_now    <= '0;
            r_min    <= vmm_pkg::VOLTS_MIN_RESET;
            r_max    <= '0;
            r_toggle <= 1'b0;
            r_tick   <= '0;
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_job    <= JOB_TICK;
        end else begin
            r_period <= n_period;
            r_now    <= n_now;
            r_min    <= n_min;
            r_max    <= n_max;
            r_toggle <= n_toggle;
            r_tick   <= n_tick;
            r_busy   <= n_busy;
            r_idx    <= n_idx;
            r_job    <= n_job;
        end
        r_last_idx <= n_last_idx;
        r_seg      <= n_seg;
        r_hi       <= n_hi;
        r_a1       <= n_a1;
        r_a0       <= n_a0;
        r_b1       <= n_b1;
        r_b0       <= n_b0;
    end

    // The result on show is chosen by the job and the position within it.
    always_comb begin
        o_kind       = 1'b1;
        o_segments   = '0;
        o_high_digit = 1'b0;
        o_tx_char    = '0;
        if (r_job == JOB_TICK) begin
            case (r_idx)
                4'd0: begin
                    o_kind       = 1'b0;
                    o_segments   = r_seg;
                    o_high_digit = r_hi;
                end
                4'd1:    o_tx_char = vmm_pkg::ascii_of(r_a1);
                4'd2:    o_tx_char = vmm_pkg::CHAR_DOT;
                4'd3:    o_tx_char = vmm_pkg::ascii_of(r_a0);
                default: o_tx_char = vmm_pkg::CHAR_NL;
            endcase
        end else begin
            case (r_idx)
                4'd0:    o_tx_char = vmm_pkg::CHAR_LOWER_M;
                4'd1:    o_tx_char = vmm_pkg::ascii_of(r_a1);
                4'd2:    o_tx_char = vmm_pkg::CHAR_DOT;
                4'd3:    o_tx_char = vmm_pkg::ascii_of(r_a0);
                4'd5:    o_tx_char = vmm_pkg::CHAR_UPPER_M;
                4'd6:    o_tx_char = vmm_pkg::ascii_of(r_b1);
                4'd7:    o_tx_char = vmm_pkg::CHAR_DOT;
                4'd8:    o_tx_char = vmm_pkg::ascii_of(r_b0);
                default: o_tx_char = vmm_pkg::CHAR_NL;
            endcase
        end
    end

    assign o_valid     = r_busy;
    assign o_last      = r_idx == r_last_idx;
    assign o_item_take = take;

endmodule

// File: hw/rtl/voltmeter_minmax_display_unit.sv
// Voltmeter with running minimum and maximum, two-digit seven-segment drive and a
// serial text report. One item can be accepted in every clock cycle while o_stall
// is low. The four sample lanes register the item at its transfer, the merging
// stage that averages and scales to tenths of a volt then registers it, and the
// sequencer shows its first result from a register of its own. The sequencer
// emits one result per cycle while i_stall is low, so a display tick without a
// report holds the output for one transfer, a tick with a report for five and an
// 'L' request for eleven; conversion bursts and ignored bytes pass through
// without occupying the output at all. Sustained throughput is therefore one
// item per cycle unless results pile up behind a multi-character report or a
// stalled receiver, in which case i_stall is passed back as o_stall through the
// pipeline.
module voltmeter_minmax_display_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // Configuration: report_period.
    input  logic                         i_cfg_wr_en,
    input  logic [vmm_pkg::PERIOD_W-1:0] i_cfg_wr_data,

    // Input channel.
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_op,
    input  logic [vmm_pkg::SAMPLE_W-1:0] i_sample_0,
    input  logic [vmm_pkg::SAMPLE_W-1:0] i_sample_1,
    input  logic [vmm_pkg::SAMPLE_W-1:0] i_sample_2,
    input  logic [vmm_pkg::SAMPLE_W-1:0] i_sample_3,
    input  logic [vmm_pkg::SAMPLE_W-1:0] i_sample_4,
    input  logic [vmm_pkg::SAMPLE_W-1:0] i_sample_5,
    input  logic [vmm_pkg::SAMPLE_W-1:0] i_sample_6,
    input  logic [vmm_pkg::SAMPLE_W-1:0] i_sample_7,
    input  logic [vmm_pkg::CHAR_W-1:0]   i_rx_byte,

    // Result channel.
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_kind,
    output logic [vmm_pkg::SEG_W-1:0]    o_segments,
    output logic                         o_high_digit,
    output logic [vmm_pkg::CHAR_W-1:0]   o_tx_char,
    output logic                         o_last
);

    logic [vmm_pkg::SAMPLE_W-1:0] samples [2*vmm_pkg::LANES];
    logic [vmm_pkg::PAIR_W-1:0]   pair_sum [vmm_pkg::LANES];
    logic [vmm_pkg::VOLTS_W-1:0]  volts;

    // Pipeline control: a stage may load when it is empty or its contents move on.
    logic                         r_s1_valid;
    logic [1:0]                   r_s1_op;
    logic [vmm_pkg::CHAR_W-1:0]   r_s1_rx;
    logic                         r_s2_valid;
    logic [1:0]                   r_s2_op;
    logic [vmm_pkg::CHAR_W-1:0]   r_s2_rx;

    logic                         in_xfer;
    logic                         s1_ready;
    logic                         s2_ready;
    logic                         s2_load;
    logic                         seq_take;
    vmm_pkg::t_item               item;

    assign samples[0] = i_sample_0;
    assign samples[1] = i_sample_1;
    assign samples[2] = i_sample_2;
    assign samples[3] = i_sample_3;
    assign samples[4] = i_sample_4;
    assign samples[5] = i_sample_5;
    assign samples[6] = i_sample_6;
    assign samples[7] = i_sample_7;

    // The sequencer takes bursts and ignored bytes at once; only items that
    // produce results wait for the output to be free.
    assign s2_ready = !r_s2_valid || seq_take;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign s2_load  = r_s1_valid && s2_ready;
    assign o_stall  = !s1_ready;
    assign in_xfer  = i_valid && s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
        if (in_xfer) begin
            r_s1_op <= i_op;
            r_s1_rx <= i_rx_byte;
        end
        if (s2_load) begin
            r_s2_op <= r_s1_op;
            r_s2_rx <= r_s1_rx;
        end
    end

    // Each lane adds one pair of samples of the burst.
    for (genvar g = 0; g < vmm_pkg::LANES; g++) begin : g_lane
        vmm_lane u_lane (
            .i_clk      (i_clk),
            .i_en       (in_xfer),
            .i_sample_a (samples[2*g]),
            .i_sample_b (samples[2*g+1]),
            .o_sum      (pair_sum[g])
        );
    end

    // The merging stage sums the lane results, averages and scales to tenths of a volt.
    vmm_merge u_merge (
        .i_clk      (i_clk),
        .i_en       (s2_load),
        .i_pair_sum (pair_sum),
        .o_volts    (volts)
    );

    assign item.op      = r_s2_op;
    assign item.rx_byte = r_s2_rx;
    assign item.volts   = volts;

    // The sequencer holds the voltage state and counters and emits each result transfer.
    vmm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item_valid  (r_s2_valid),
        .i_item        (item),
        .o_item_take   (seq_take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_segments    (o_segments),
        .o_high_digit  (o_high_digit),
        .o_tx_char     (o_tx_char),
        .o_last        (o_last)
    );

endmodule
